@@ src/u8jh_pkg.sv @@
package u8jh_pkg;

  localparam int UNIT_W   = 16;
  localparam int HASH_W   = 32;
  localparam int MAX_UNITS = 4;
  localparam int Q_DEPTH  = 2;
  localparam int Q_AW     = 1;

  localparam logic [UNIT_W-1:0] QMARK_UNIT = 16'h003F;
  localparam logic [HASH_W-1:0] P31_1 = 32'd31;
  localparam logic [HASH_W-1:0] P31_2 = 32'd961;
  localparam logic [HASH_W-1:0] P31_3 = 32'd29791;
  localparam logic [HASH_W-1:0] P31_4 = 32'd923521;

  // Units of one byte, right-aligned: slot 0 is the latest unit and gets weight 31^0.
  typedef struct packed {
    logic [MAX_UNITS-1:0][UNIT_W-1:0] units;
    logic [2:0]                       count;
    logic                             emit;
  } u8jh_tok_t;

  function automatic logic [HASH_W-1:0] pow31(input logic [2:0] k);
    logic [HASH_W-1:0] r;
    case (k)
      3'd0:    r = 32'd1;
      3'd1:    r = P31_1;
      3'd2:    r = P31_2;
      3'd3:    r = P31_3;
      3'd4:    r = P31_4;
      default: r = 32'd1;
    endcase
    return r;
  endfunction

endpackage

@@ src/u8jh_front.sv @@
module u8jh_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              acc,
  input  logic [7:0]        data_byte,
  input  logic              last,
  output u8jh_pkg::u8jh_tok_t tok
);
  import u8jh_pkg::*;

  logic [23:0] pend_bytes, pend_bytes_next;
  logic [1:0]  pend_cnt, pend_cnt_next;

  logic [7:0]  lead, c1, c2;
  logic        is_cont, lead_ok;
  logic [2:0]  need, cnt, n;
  logic [20:0] cp, off;
  logic        sp0, sp1;
  logic [15:0] u0, u1;

  always_comb begin
    lead    = pend_bytes[7:0];
    c1      = pend_bytes[15:8];
    c2      = pend_bytes[23:16];
    is_cont = (pend_cnt != 2'd0) && (data_byte[7:6] == 2'b10);
    lead_ok = (data_byte[7:5] == 3'b110) || (data_byte[7:4] == 4'b1110) ||
              (data_byte[7:3] == 5'b11110);
    if (lead[7:5] == 3'b110)       need = 3'd2;
    else if (lead[7:4] == 4'b1110) need = 3'd3;
    else                           need = 3'd4;
    cnt = {1'b0, pend_cnt} + 3'd1;
    case (need)
      3'd2:    cp = {10'd0, lead[4:0], data_byte[5:0]};
      3'd3:    cp = {5'd0, lead[3:0], c1[5:0], data_byte[5:0]};
      default: cp = {lead[2:0], c1[5:0], c2[5:0], data_byte[5:0]};
    endcase
    off = cp - 21'h010000;

    pend_bytes_next = 24'd0;
    pend_cnt_next   = 2'd0;
    n   = 3'd0;
    sp0 = 1'b0;
    sp1 = 1'b0;
    u0  = 16'd0;
    u1  = 16'd0;
    tok.emit = last;

    if (is_cont) begin
      if (cnt < need) begin
        if (last) begin
          n = cnt;
        end else begin
          pend_bytes_next = pend_bytes;
          if (pend_cnt == 2'd1) pend_bytes_next[15:8] = data_byte;
          else                  pend_bytes_next[23:16] = data_byte;
          pend_cnt_next = cnt[1:0];
        end
      end else if (cp > 21'h00FFFF) begin
        n   = 3'd2;
        sp1 = 1'b1;
        sp0 = 1'b1;
        u1  = 16'hD800 + {5'd0, off[20:10]};
        u0  = {6'b110111, off[9:0]};
      end else begin
        n   = 3'd1;
        sp0 = 1'b1;
        u0  = cp[15:0];
      end
    end else begin
      // broken or no sequence: buffered bytes become '?' ahead of whatever the new byte yields
      if (data_byte == 8'd0) begin
        tok.emit = 1'b1;
        n = {1'b0, pend_cnt};
      end else if (data_byte[7] == 1'b0) begin
        n   = cnt;
        sp0 = 1'b1;
        u0  = {8'd0, data_byte};
      end else if (lead_ok && !last) begin
        n = {1'b0, pend_cnt};
        pend_bytes_next = {16'd0, data_byte};
        pend_cnt_next   = 2'd1;
      end else begin
        n = cnt;
      end
    end

    tok.count = n;
    for (int i = 0; i < MAX_UNITS; i++) begin
      tok.units[i] = (3'(i) < n) ? QMARK_UNIT : 16'd0;
    end
    if (sp0) tok.units[0] = u0;
    if (sp1) tok.units[1] = u1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_bytes <= 24'd0;
      pend_cnt   <= 2'd0;
    end else if (acc) begin
      pend_bytes <= pend_bytes_next;
      pend_cnt   <= pend_cnt_next;
    end
  end

endmodule

@@ src/u8jh_queue.sv @@
module u8jh_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  u8jh_pkg::u8jh_tok_t push_tok,
  output logic              full,
  input  logic              pop,
  output logic              avail,
  output u8jh_pkg::u8jh_tok_t pop_tok
);
  import u8jh_pkg::*;

  u8jh_tok_t          mem [Q_DEPTH];
  logic [Q_AW-1:0]    wr_ptr, rd_ptr;
  logic [Q_AW:0]      fill;

  assign full    = (fill == (Q_AW+1)'(Q_DEPTH));
  assign avail   = (fill != '0);
  assign pop_tok = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule

@@ src/u8jh_back.sv @@
module u8jh_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               avail,
  input  u8jh_pkg::u8jh_tok_t  tok,
  output logic               pop,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic signed [31:0] m_axis_tdata
);
  import u8jh_pkg::*;

  // stage A: weighted sum of the byte's units and the power of 31 for the hash
  logic              a_valid, a_emit, a_go, a_ready;
  logic [HASH_W-1:0] a_poly, a_mult, poly_next;
  logic [HASH_W-1:0] hash, hash_next;

  assign poly_next = {16'd0, tok.units[0]} +
                     {16'd0, tok.units[1]} * P31_1 +
                     {16'd0, tok.units[2]} * P31_2 +
                     {16'd0, tok.units[3]} * P31_3;

  assign a_go    = a_valid && (!a_emit || !m_axis_tvalid || m_axis_tready);
  assign a_ready = !a_valid || a_go;
  assign pop     = avail && a_ready;
  assign hash_next = hash * a_mult + a_poly;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_poly <= poly_next;
      a_mult <= pow31(tok.count);
      a_emit <= tok.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (a_go) begin
        if (a_emit) hash <= '0;
        else        hash <= hash_next;
      end
      if (a_go && a_emit)     m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go && a_emit) m_axis_tdata <= $signed(hash_next);
  end

endmodule

@@ src/utf8_java_string_hash_core.sv @@
// Java String.hashCode of a UTF-8 byte stream, decoded to UTF-16 units on the fly.
// One byte is taken per cycle unless the queue is full; a string ends at a zero
// byte or tlast. The rate is set by the hash recurrence, one multiply by a power
// of 31 plus an add per byte, which folds all units a byte yields (up to four) at
// once. Malformed sequences fold '?' per buffered byte; overlong forms are decoded
// as written. A stalled result holds the output register and a string end in stage
// A; the decoder keeps taking bytes until its queue fills.
module utf8_java_string_hash_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,  // [7:0] data_byte
  input  logic               s_axis_tlast,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic signed [31:0] m_axis_tdata   // [31:0] hash_value
);
  import u8jh_pkg::*;

  logic      acc, q_full, q_avail, q_pop;
  u8jh_tok_t f_tok, q_tok;

  assign s_axis_tready = !q_full;
  assign acc = s_axis_tvalid && s_axis_tready;

  u8jh_front u_front (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .data_byte (s_axis_tdata),
    .last      (s_axis_tlast),
    .tok       (f_tok)
  );

  u8jh_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (acc),
    .push_tok (f_tok),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .pop_tok  (q_tok)
  );

  u8jh_back u_back (
    .clk           (clk),
    .rst           (rst),
    .avail         (q_avail),
    .tok           (q_tok),
    .pop           (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
